@@ hdl/motor_feedback_turn_tracker_assert.svh @@
// ----------------------------------------------------------------------------
// Motor feedback turn tracker assertion macros
// Concurrent assertion wrappers that drop out of synthesis builds.
// ----------------------------------------------------------------------------
`ifndef MOTOR_FEEDBACK_TURN_TRACKER_ASSERT_SVH
`define MOTOR_FEEDBACK_TURN_TRACKER_ASSERT_SVH

`ifndef SYNTHESIS

// Checked only while the block is out of reset.
`define MFTT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("motor_feedback_turn_tracker: assertion failed");

// Checked at every edge, reset included.
`define MFTT_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("motor_feedback_turn_tracker: assertion failed");

`else

`define MFTT_ASSERT(label, clk, rst_n, prop)
`define MFTT_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

@@ hdl/mftt_pkg.sv @@
// ----------------------------------------------------------------------------
// Motor feedback turn tracker package
// Shared constants, register indexes and record types of the tracker.
// ----------------------------------------------------------------------------
package mftt_pkg;

    // Number of motor slots and the width of a slot index.
    localparam int NUM_MOTORS = 8;
    localparam int SLOT_W     = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

    // Field widths.
    localparam int ID_W       = 11;
    localparam int ANGLE_W    = 16;
    localparam int WORD_W     = 16;
    localparam int TEMP_W     = 8;
    localparam int TURN_W     = 18;
    localparam int TOTAL_W    = 32;
    localparam int COUNT_W    = 16;
    localparam int OUT_SLOT_W = 3;
    localparam int TURN_SHIFT = 13;   // 8192 counts per turn

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_ID  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_THR = 1'd1;
    localparam logic [ID_W-1:0]      BASE_ID_RST  = 11'd513;
    localparam logic [WORD_W-1:0]    WRAP_THR_RST = 16'd6000;

    // Stream widths.
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 128;

    // Saturation limits of the turn counter.
    localparam logic signed [TURN_W-1:0] TURN_MAX = 18'sh1FFFF;
    localparam logic signed [TURN_W-1:0] TURN_MIN = 18'sh20000;

    // Raw frame as received.
    typedef struct packed {
        logic [ID_W-1:0] frame_id;
        logic [7:0]      angle_high;
        logic [7:0]      angle_low;
        logic [7:0]      speed_high;
        logic [7:0]      speed_low;
        logic [7:0]      current_high;
        logic [7:0]      current_low;
        logic [7:0]      temp_byte;
    } t_raw_frame;

    // Decoded frame with slot selection.
    typedef struct packed {
        logic                      id_error;
        logic [ID_W-1:0]           slot_offset;
        logic [ANGLE_W-1:0]        angle;
        logic signed [WORD_W-1:0]  speed;
        logic signed [WORD_W-1:0]  current;
        logic [TEMP_W-1:0]         temp;
    } t_frame;

    // Per-slot tracking result.
    typedef struct packed {
        logic signed [TURN_W-1:0]  turns;
        logic signed [TOTAL_W-1:0] total_angle;
        logic [COUNT_W-1:0]        frame_count;
    } t_track;

endpackage

@@ hdl/mftt_decode.sv @@
// ----------------------------------------------------------------------------
// Motor feedback frame decoder
// Assembles the big-endian payload fields and selects the motor slot.
// ----------------------------------------------------------------------------
module mftt_decode (
    input  mftt_pkg::t_raw_frame      i_raw,
    input  logic [mftt_pkg::ID_W-1:0] i_base_id,
    output mftt_pkg::t_frame          o_frame
);
    import mftt_pkg::*;

    logic [ID_W-1:0] slot_offset;

    // Slot offset wraps modulo the identifier range.
    assign slot_offset = i_raw.frame_id - i_base_id;

    // Payload fields and the out-of-range check.
    always_comb begin
        o_frame.slot_offset = slot_offset;
        o_frame.id_error    = (slot_offset >= ID_W'(NUM_MOTORS));
        o_frame.angle       = {i_raw.angle_high, i_raw.angle_low};
        o_frame.speed       = $signed({i_raw.speed_high, i_raw.speed_low});
        o_frame.current     = $signed({i_raw.current_high, i_raw.current_low});
        o_frame.temp        = i_raw.temp_byte;
    end

endmodule

@@ hdl/mftt_slot_track.sv @@
// ----------------------------------------------------------------------------
// Motor slot turn tracker
// Holds the per-slot angle, turn and frame state and unwraps the angle.
// ----------------------------------------------------------------------------
module mftt_slot_track (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_update,
    input  mftt_pkg::t_frame            i_frame,
    input  logic [mftt_pkg::WORD_W-1:0] i_wrap_thr,
    output mftt_pkg::t_track            o_track
);
    import mftt_pkg::*;

    logic [ANGLE_W-1:0]       r_last_angle [NUM_MOTORS];
    logic signed [TURN_W-1:0] r_turns      [NUM_MOTORS];
    logic [COUNT_W-1:0]       r_frames     [NUM_MOTORS];

    logic [SLOT_W-1:0]          slot;
    logic [ANGLE_W-1:0]         last_angle;
    logic signed [TURN_W-1:0]   cur_turns;
    logic signed [ANGLE_W:0]    drop;
    logic signed [ANGLE_W:0]    rise;
    logic signed [ANGLE_W:0]    thr;
    logic signed [TURN_W-1:0]   n_turns;
    logic [COUNT_W-1:0]         n_frames;
    logic signed [TOTAL_W-1:0]  turn_counts;

    assign slot       = i_frame.slot_offset[SLOT_W-1:0];
    assign last_angle = r_last_angle[slot];
    assign cur_turns  = r_turns[slot];

    // A large drop is a forward wrap, a large rise a backward wrap.
    assign drop = $signed({1'b0, last_angle}) - $signed({1'b0, i_frame.angle});
    assign rise = $signed({1'b0, i_frame.angle}) - $signed({1'b0, last_angle});
    assign thr  = $signed({1'b0, i_wrap_thr});

    always_comb begin
        n_turns = cur_turns;
        if (drop > thr) begin
            if (cur_turns != TURN_MAX) begin
                n_turns = cur_turns + TURN_W'(1);
            end
        end else if (rise > thr) begin
            if (cur_turns != TURN_MIN) begin
                n_turns = cur_turns - TURN_W'(1);
            end
        end
    end

    assign n_frames = r_frames[slot] + COUNT_W'(1);

    // Total angle is the single-turn angle plus turns times 8192.
    assign turn_counts = $signed({{(TOTAL_W-TURN_W-TURN_SHIFT){n_turns[TURN_W-1]}},
                                  n_turns, {TURN_SHIFT{1'b0}}});

    // An erroneous frame reports zeros.
    always_comb begin
        if (i_frame.id_error) begin
            o_track = '0;
        end else begin
            o_track.turns       = n_turns;
            o_track.total_angle = turn_counts + $signed({{(TOTAL_W-ANGLE_W){1'b0}},
                                                         i_frame.angle});
            o_track.frame_count = n_frames;
        end
    end

    // Slot state is written only for frames with a valid identifier.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_MOTORS; i++) begin
                r_last_angle[i] <= '0;
                r_turns[i]      <= '0;
                r_frames[i]     <= '0;
            end
        end else if (i_update && !i_frame.id_error) begin
            r_last_angle[slot] <= i_frame.angle;
            r_turns[slot]      <= n_turns;
            r_frames[slot]     <= n_frames;
        end
    end

endmodule

@@ hdl/motor_feedback_turn_tracker.sv @@
// ----------------------------------------------------------------------------
// Motor feedback turn tracker
// Decodes motor feedback frames and keeps a multi-turn angle per motor slot.
// ----------------------------------------------------------------------------
// Usage:
// Frames enter on the s_axis channel and one result leaves on m_axis for
// every frame. A frame transfer lands in an input register; when the output
// register is free, the decoder and slot tracker produce the result and
// update the slot state, and the result is registered in the output register,
// from which it is offered. One frame per cycle is sustained while the
// receiver takes every result, since the slot state is written at the same
// edge the result is registered and the next frame already sees it.
// When the receiver stalls, the output register holds its result and the
// input register holds the next frame; input ready drops only when both
// are full.
// Reset empties both registers, clears all slot state and loads the defaults
// (base identifier 513, wrap threshold 6000). Config writes take effect at the
// next edge; the user must make them while the block is idle (not enforced).
// ----------------------------------------------------------------------------
`include "motor_feedback_turn_tracker_assert.svh"

module motor_feedback_turn_tracker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port.
    input  logic                                i_cfg_wen,
    input  logic [mftt_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [mftt_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    // Frame input. tdata from bit 0: frame_id, angle_high, angle_low,
    // speed_high, speed_low, current_high, current_low, temp_byte, zero pad.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [mftt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // Result output. tdata from bit 0: motor_slot, angle_out, speed_out,
    // current_out, temp_out, turns, total_angle, frame_count, zero pad.
    // tuser: id_error.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [mftt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tuser
);
    import mftt_pkg::*;

    localparam int OUT_USED_W = OUT_SLOT_W + ANGLE_W + 2 * WORD_W + TEMP_W
                              + TURN_W + TOTAL_W + COUNT_W;

    logic [ID_W-1:0]    r_base_id;
    logic [WORD_W-1:0]  r_wrap_thr;
    logic               r_in_valid;
    t_raw_frame         r_in;
    logic               r_out_valid;
    logic               r_out_err;
    logic [OUT_USED_W-1:0] r_out_data;

    logic       advance;
    t_raw_frame raw_in;
    t_frame     frame;
    t_track     track;
    logic [OUT_SLOT_W-1:0] out_slot;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_id  <= BASE_ID_RST;
            r_wrap_thr <= WRAP_THR_RST;
        end else if (i_cfg_wen) begin
            case (i_cfg_idx)
                REG_BASE_ID:  r_base_id  <= i_cfg_wdata[ID_W-1:0];
                REG_WRAP_THR: r_wrap_thr <= i_cfg_wdata[WORD_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: the input register moves on when the output is free.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // Unpack the input transfer.
    always_comb begin
        raw_in.frame_id     = s_axis_tdata[10:0];
        raw_in.angle_high   = s_axis_tdata[18:11];
        raw_in.angle_low    = s_axis_tdata[26:19];
        raw_in.speed_high   = s_axis_tdata[34:27];
        raw_in.speed_low    = s_axis_tdata[42:35];
        raw_in.current_high = s_axis_tdata[50:43];
        raw_in.current_low  = s_axis_tdata[58:51];
        raw_in.temp_byte    = s_axis_tdata[66:59];
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in <= raw_in;
        end
    end

    mftt_decode u_decode (
        .i_raw     (r_in),
        .i_base_id (r_base_id),
        .o_frame   (frame)
    );

    mftt_slot_track u_slot_track (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_update   (advance),
        .i_frame    (frame),
        .i_wrap_thr (r_wrap_thr),
        .o_track    (track)
    );

    assign out_slot = frame.id_error ? '0 : frame.slot_offset[OUT_SLOT_W-1:0];

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_err  <= frame.id_error;
            r_out_data <= {track.frame_count, track.total_angle, track.turns,
                           frame.temp, frame.current, frame.speed, frame.angle,
                           out_slot};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_err;
    assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_USED_W){1'b0}}, r_out_data};

    // Reset empties the output register.
    `MFTT_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> !m_axis_tvalid)

    // A rejected identifier carries no slot, turn, total or count.
    `MFTT_ASSERT(a_error_zero, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[2:0] == 3'd0 && m_axis_tdata[124:59] == 66'd0))

    // Total angle of an accepted identifier equals angle plus turns times 8192.
    `MFTT_ASSERT(a_total_consistent, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[108:77] == ({{14{m_axis_tdata[76]}}, m_axis_tdata[76:59]} * 32'd8192 + {16'd0, m_axis_tdata[18:3]})))

    // The input register cannot be loaded while it holds a frame it cannot pass on.
    `MFTT_ASSERT(a_no_overrun, i_clk, i_rst_n, (r_in_valid && r_out_valid && !m_axis_tready) |-> !s_axis_tready)

endmodule

@@ bench/motor_feedback_turn_tracker_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor feedback turn tracker testbench
// Sends feedback frames over the input stream and checks every result against
// a cycle-free model of the decoder and the per-slot turn tracking. A short
// table of frames covers reset state, field extremes, identifier errors and
// the exact wrap threshold. Random frames follow under several register
// settings, with both stream sides idling.
// ----------------------------------------------------------------------------
module motor_feedback_turn_tracker_tb;

    import mftt_pkg::*;

    localparam int HOLD_CYCLES = 60;
    localparam int QUIET_LIMIT = 4000;
    localparam int PRINT_LIMIT = 20;

    // One decoded result as it leaves the block.
    typedef struct packed {
        logic [OUT_SLOT_W-1:0]     slot;
        logic                      err;
        logic [ANGLE_W-1:0]        angle;
        logic signed [WORD_W-1:0]  speed;
        logic signed [WORD_W-1:0]  current;
        logic [TEMP_W-1:0]         temp;
        logic signed [TURN_W-1:0]  turns;
        logic signed [TOTAL_W-1:0] total;
        logic [COUNT_W-1:0]        count;
    } t_fb_result;

    // One row of the directed frame table.
    typedef struct packed {
        t_raw_frame frame;
        logic       typed;
        t_fb_result want;
    } t_frame_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = REG_BASE_ID;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;

    // Register shadows and per-slot tracking state of the model.
    logic [ID_W-1:0]          cur_base = BASE_ID_RST;
    logic [WORD_W-1:0]        cur_thr = WRAP_THR_RST;
    logic [ANGLE_W-1:0]       slot_angle [NUM_MOTORS];
    logic signed [TURN_W-1:0] slot_turns [NUM_MOTORS];
    logic [COUNT_W-1:0]       slot_frames [NUM_MOTORS];

    t_fb_result fb_expected [$];
    t_frame_row frame_table [$];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_req = 1'b0;
    int  mismatches = 0;
    int  frames_in = 0;
    int  results_seen = 0;
    int  quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    motor_feedback_turn_tracker DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // frame_id, angle_hi, angle_lo, speed_hi,
                                         // speed_lo, current_hi, current_lo, temp
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // slot, angle, speed, current, temp,
                                         // turns, total_angle, frame_count
        .m_axis_tuser  (m_axis_tuser)    // id_error
    );

    initial begin
        for (int i = 0; i < NUM_MOTORS; i++) begin
            slot_angle[i]  = '0;
            slot_turns[i]  = '0;
            slot_frames[i] = '0;
        end
    end

    // Decode one frame and advance the tracking state of its slot.
    function automatic t_fb_result track_frame(input t_raw_frame f);
        t_fb_result               r;
        logic [ID_W-1:0]          sel;
        logic signed [TURN_W-1:0] t;
        int                       idx;
        int                       step;
        r         = '0;
        r.angle   = {f.angle_high, f.angle_low};
        r.speed   = {f.speed_high, f.speed_low};
        r.current = {f.current_high, f.current_low};
        r.temp    = f.temp_byte;
        sel       = f.frame_id - cur_base;
        if (sel >= NUM_MOTORS) begin
            r.err = 1'b1;
        end else begin
            idx  = int'(sel);
            step = int'(r.angle) - int'(slot_angle[idx]);
            t    = slot_turns[idx];
            // A large drop is a forward wrap, a large rise a backward one.
            if (step < -int'(cur_thr)) begin
                if (t != TURN_MAX) t = t + TURN_W'(1);
            end else if (step > int'(cur_thr)) begin
                if (t != TURN_MIN) t = t - TURN_W'(1);
            end
            slot_turns[idx]  = t;
            slot_angle[idx]  = r.angle;
            slot_frames[idx] = slot_frames[idx] + 1'b1;
            r.slot  = idx[OUT_SLOT_W-1:0];
            r.turns = t;
            r.total = int'(r.angle) + (int'(t) <<< TURN_SHIFT);
            r.count = slot_frames[idx];
        end
        return r;
    endfunction

    // Random frame: mostly valid slots with angle moves that probe the
    // threshold and the wrap point, the rest bad identifiers and noise.
    function automatic t_raw_frame make_frame();
        t_raw_frame  f;
        int          idx;
        int          last;
        int          step;
        int          na;
        logic [15:0] spd;
        logic [15:0] cur;
        idx = $urandom_range(NUM_MOTORS - 1, 0);
        case ($urandom_range(99, 0)) inside
            [0:77]:  f.frame_id = ID_W'(int'(cur_base) + idx);
            [78:81]: f.frame_id = cur_base - ID_W'(1);
            [82:85]: f.frame_id = cur_base + ID_W'(NUM_MOTORS);
            default: f.frame_id = ID_W'($urandom_range(2047, 0));
        endcase
        last = int'(slot_angle[idx]);
        case ($urandom_range(99, 0)) inside
            [0:34]: begin
                step = int'(cur_thr) + int'($urandom_range(4, 0)) - 2;
                na = $urandom_range(1, 0) ? last + step : last - step;
                if (na < 0 || na > 65535) na = $urandom_range(65535, 0);
            end
            [35:59]: begin
                na = (last >= 32768) ? int'($urandom_range(2000, 0))
                                     : 65535 - int'($urandom_range(2000, 0));
            end
            [60:79]: begin
                na = last + int'($urandom_range(1000, 0)) - 500;
                if (na < 0) na = 0;
                if (na > 65535) na = 65535;
            end
            [80:84]: na = $urandom_range(1, 0) ? 65535 : 0;
            default: na = $urandom_range(65535, 0);
        endcase
        spd = 16'($urandom_range(65535, 0));
        cur = 16'($urandom_range(65535, 0));
        if ($urandom_range(9, 0) == 0) spd = $urandom_range(1, 0) ? 16'h7FFF : 16'h8000;
        if ($urandom_range(9, 0) == 0) cur = $urandom_range(1, 0) ? 16'hFFFF : 16'h0000;
        f.angle_high   = na[15:8];
        f.angle_low    = na[7:0];
        f.speed_high   = spd[15:8];
        f.speed_low    = spd[7:0];
        f.current_high = cur[15:8];
        f.current_low  = cur[7:0];
        f.temp_byte    = 8'($urandom_range(255, 0));
        return f;
    endfunction

    function automatic void add_row(input logic [ID_W-1:0] id, input logic [15:0] ang,
                                    input logic [15:0] spd, input logic [15:0] cur,
                                    input logic [7:0] tmp, input int typed,
                                    input int e_slot, input int e_err,
                                    input int e_turns, input int e_total, input int e_count);
        t_frame_row row;
        row.frame.frame_id     = id;
        row.frame.angle_high   = ang[15:8];
        row.frame.angle_low    = ang[7:0];
        row.frame.speed_high   = spd[15:8];
        row.frame.speed_low    = spd[7:0];
        row.frame.current_high = cur[15:8];
        row.frame.current_low  = cur[7:0];
        row.frame.temp_byte    = tmp;
        row.typed              = (typed != 0);
        row.want.slot          = OUT_SLOT_W'(e_slot);
        row.want.err           = (e_err != 0);
        row.want.angle         = ang;
        row.want.speed         = spd;
        row.want.current       = cur;
        row.want.temp          = tmp;
        row.want.turns         = TURN_W'(e_turns);
        row.want.total         = e_total;
        row.want.count         = COUNT_W'(e_count);
        frame_table.push_back(row);
    endfunction

    task automatic report(input string msg);
        if (mismatches < PRINT_LIMIT) $display("%0t: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report($sformatf("result %0d %s got 0x%0h expected 0x%0h",
                             results_seen, name, got, want));
    endtask

    // Offer one frame and queue its expected result once the transfer is made.
    task automatic send_frame(input t_raw_frame f, input logic typed,
                              input t_fb_result want);
        t_fb_result pred;
        s_axis_tdata  <= {5'b0, f.temp_byte, f.current_low, f.current_high,
                          f.speed_low, f.speed_high, f.angle_low, f.angle_high,
                          f.frame_id};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pred = track_frame(f);
        fb_expected.push_back(typed ? want : pred);
        frames_in++;
        if ($urandom_range(99, 0) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99, 0) < send_idle_pct);
        end
    endtask

    task automatic run_random(input int n, input int hold_at);
        for (int i = 0; i < n; i++) begin
            if (i == hold_at) hold_req = 1'b1;
            send_frame(make_frame(), 1'b0, '0);
        end
    endtask

    // Stop offering and wait until every result is back.
    task automatic finish_phase();
        s_axis_tvalid <= 1'b0;
        while (fb_expected.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [ID_W-1:0] base, input logic [WORD_W-1:0] thr);
        i_cfg_wen   <= 1'b1;
        i_cfg_idx   <= REG_BASE_ID;
        i_cfg_wdata <= {5'b0, base};
        @(posedge i_clk);
        i_cfg_idx   <= REG_WRAP_THR;
        i_cfg_wdata <= thr;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
        cur_base = base;
        cur_thr  = thr;
    endtask

    // Result sink with random stalls and an occasional long hold-off.
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
            end
        end
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_fb_result got;
        t_fb_result want;
        if (m_axis_tvalid && m_axis_tready) begin
            got.slot    = m_axis_tdata[2:0];
            got.angle   = m_axis_tdata[18:3];
            got.speed   = m_axis_tdata[34:19];
            got.current = m_axis_tdata[50:35];
            got.temp    = m_axis_tdata[58:51];
            got.turns   = m_axis_tdata[76:59];
            got.total   = m_axis_tdata[108:77];
            got.count   = m_axis_tdata[124:109];
            got.err     = m_axis_tuser;
            if (fb_expected.size() == 0) begin
                report($sformatf("result %0d arrived with nothing expected", results_seen));
            end else begin
                want = fb_expected.pop_front();
                check_field("motor_slot", 32'(got.slot), 32'(want.slot));
                check_field("id_error", 32'(got.err), 32'(want.err));
                check_field("angle_out", 32'(got.angle), 32'(want.angle));
                check_field("speed_out", 32'(got.speed), 32'(want.speed));
                check_field("current_out", 32'(got.current), 32'(want.current));
                check_field("temp_out", 32'(got.temp), 32'(want.temp));
                check_field("turns", 32'(got.turns), 32'(want.turns));
                check_field("total_angle", got.total, want.total);
                check_field("frame_count", 32'(got.count), 32'(want.count));
            end
            results_seen++;
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("motor_feedback_turn_tracker_tb: done, errors");
                $finish;
            end
        end
    end

    initial begin : stimulus
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames at the reset settings (base 513, threshold 6000).
        // Slot 0 and slot 7 at the payload extremes.
        add_row(11'd513, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1, 0, 0, 0, 0, 1);
        add_row(11'd520, 16'hFFFF, 16'h7FFF, 16'h8000, 8'hFF, 1, 7, 0, -1, 57343, 1);
        add_row(11'd520, 16'h0000, 16'h8000, 16'h7FFF, 8'h00, 1, 7, 0, 0, 0, 2);
        // Identifiers outside the slots: payload decoded, nothing else.
        add_row(11'd512, 16'h1234, 16'hFFFF, 16'h0001, 8'h80, 1, 0, 1, 0, 0, 0);
        add_row(11'd521, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1, 0, 1, 0, 0, 0);
        add_row(11'd0,   16'h0000, 16'h0001, 16'hFFFF, 8'h01, 1, 0, 1, 0, 0, 0);
        add_row(11'd2047, 16'hABCD, 16'h5555, 16'hAAAA, 8'h55, 1, 0, 1, 0, 0, 0);
        // Jumps of exactly the threshold do not count, one more does.
        add_row(11'd514, 16'h1770, 16'h0102, 16'hFEFD, 8'h30, 1, 1, 0, 0, 6000, 1);
        add_row(11'd514, 16'h0000, 16'h0304, 16'hFCFB, 8'h31, 1, 1, 0, 0, 0, 2);
        add_row(11'd514, 16'h1771, 16'h0506, 16'hFAF9, 8'h32, 1, 1, 0, -1, -2191, 3);
        add_row(11'd514, 16'h0000, 16'h0708, 16'hF8F7, 8'h33, 1, 1, 0, 0, 0, 4);
        add_row(11'd514, 16'hFFFF, 16'h090A, 16'hF6F5, 8'h34, 1, 1, 0, -1, 57343, 5);
        add_row(11'd514, 16'h0000, 16'h0B0C, 16'hF4F3, 8'h35, 1, 1, 0, 0, 0, 6);
        // Mixed traffic on the remaining slots.
        add_row(11'd515, 16'h8000, 16'h1357, 16'h2468, 8'h40, 0, 0, 0, 0, 0, 0);
        add_row(11'd516, 16'h4000, 16'hC001, 16'h3FFE, 8'h41, 0, 0, 0, 0, 0, 0);
        add_row(11'd517, 16'hC000, 16'h8001, 16'h7FFE, 8'h42, 0, 0, 0, 0, 0, 0);
        add_row(11'd518, 16'h7FFF, 16'h00FF, 16'hFF00, 8'h7F, 0, 0, 0, 0, 0, 0);
        add_row(11'd519, 16'h8001, 16'hFF00, 16'h00FF, 8'hFE, 0, 0, 0, 0, 0, 0);
        add_row(11'd515, 16'h0FFF, 16'h2222, 16'hDDDD, 8'h10, 0, 0, 0, 0, 0, 0);
        add_row(11'd513, 16'hE890, 16'h6666, 16'h9999, 8'h20, 0, 0, 0, 0, 0, 0);
        add_row(11'd516, 16'hF000, 16'h1111, 16'hEEEE, 8'h21, 0, 0, 0, 0, 0, 0);

        send_idle_pct = 22;
        recv_idle_pct = 74;
        foreach (frame_table[i])
            send_frame(frame_table[i].frame, frame_table[i].typed, frame_table[i].want);
        run_random(200, -1);
        finish_phase();

        // Random base, moderate threshold.
        set_regs(ID_W'($urandom_range(2047, 0)), WORD_W'($urandom_range(20000, 100)));
        send_idle_pct = 74;
        recv_idle_pct = 22;
        run_random(250, -1);
        finish_phase();

        // Top base with slot identifiers wrapping past zero, widest threshold;
        // the sink holds off for a while so the input backs up.
        set_regs(11'd2047, 16'hFFFF);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(250, 80);
        finish_phase();

        // Lowest base and a zero threshold: every move counts.
        set_regs(11'd0, 16'h0000);
        send_idle_pct = 22;
        recv_idle_pct = 74;
        run_random(250, -1);
        finish_phase();

        set_regs(11'd2044, 16'h0001);
        send_idle_pct = 74;
        recv_idle_pct = 22;
        run_random(200, -1);
        finish_phase();

        set_regs(ID_W'($urandom_range(2047, 0)), WORD_W'($urandom_range(65535, 0)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(250, -1);
        finish_phase();
        repeat (10) @(posedge i_clk);

        $display("Sent %0d frames over six register settings, with both idle mixes",
                 frames_in);
        $display("and a sink hold-off; %0d results checked, %0d mismatches.",
                 results_seen, mismatches);
        if (mismatches == 0 && fb_expected.size() == 0) begin
            $display("motor_feedback_turn_tracker_tb: done, clean");
        end else begin
            $display("motor_feedback_turn_tracker_tb: done, errors");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/mftt_pkg.sv
hdl/mftt_decode.sv
hdl/mftt_slot_track.sv
hdl/motor_feedback_turn_tracker.sv
bench/motor_feedback_turn_tracker_tb.sv
